### rtl/lsw_pkg.sv
// ----------------------------------------------------------------------------
// Lap stopwatch package
// Field widths, arithmetic constants, command and status codes, and the
// result record shared by the stopwatch modules.
// ----------------------------------------------------------------------------
package lsw_pkg;

    localparam int LAP_DEPTH_DEF = 64;

    localparam int CMD_W    = 3;
    localparam int TICKS_W  = 16;
    localparam int INDEX_W  = 6;
    localparam int PERIOD_W = 16;
    localparam int VALUE_W  = 32;
    localparam int LAPS_W   = 7;
    localparam int HOURS_W  = 11;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int MS_W     = 10;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    // Sub-period time: floor(ticks * 305 / 10000). The division uses a
    // rounded-up reciprocal that is exact for every 25-bit product.
    localparam int SUB_MUL     = 305;
    localparam int SUB_DIV     = 10000;
    localparam int SUB_SHIFT   = 39;
    localparam int SUB_PROD_W  = 25;
    localparam int SUB_RECIP_W = 26;
    localparam int SUB_W       = 11;
    localparam longint unsigned SUB_RECIP =
        ((64'd1 << SUB_SHIFT) + longint'(SUB_DIV) - 64'd1) / longint'(SUB_DIV);

    // Time format divisors and the reciprocal shifts used for each of them.
    localparam int unsigned HOUR_MS   = 3600000;
    localparam int unsigned MINUTE_MS = 60000;
    localparam int unsigned SECOND_MS = 1000;
    localparam int HOUR_SHIFT   = 32;
    localparam int MINUTE_SHIFT = 32;
    localparam int SECOND_SHIFT = 26;

    typedef enum logic [CMD_W-1:0] {
        CMD_PERIOD   = 3'd0,
        CMD_RESET    = 3'd1,
        CMD_START    = 3'd2,
        CMD_STOP     = 3'd3,
        CMD_LAP      = 3'd4,
        CMD_RD_TOTAL = 3'd5,
        CMD_RD_SUM   = 3'd6,
        CMD_RD_LAP   = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_UNWRITTEN = 2'd2
    } status_t;

    // Which value a result reports.
    typedef enum logic [1:0] {
        SEL_TOTAL = 2'd0,
        SEL_SUM   = 2'd1,
        SEL_LAP   = 2'd2
    } sel_t;

    typedef struct packed {
        status_t              status;
        logic                 running;
        logic [LAPS_W-1:0]    laps;
        logic [VALUE_W-1:0]   value;
    } res_info_t;

endpackage

### rtl/lsw_ram.sv
// ----------------------------------------------------------------------------
// Lap stopwatch RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/lsw_cdiv.sv
// ----------------------------------------------------------------------------
// Lap stopwatch constant divider
// Three-stage quotient and remainder by a constant: reciprocal multiply,
// back multiply, then one compare-and-subtract correction.
// ----------------------------------------------------------------------------
module lsw_cdiv
    import lsw_pkg::*;
#(
    parameter int          DIVIDEND_W = 32,
    parameter int          QUOT_W     = 11,
    parameter int unsigned DIVISOR    = 3600000,
    parameter int          SHIFT      = 32,
    parameter int          SB_W       = 8,
    parameter int          REM_W      = $clog2(DIVISOR)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DIVIDEND_W-1:0] in_x,
    input  logic [SB_W-1:0]       in_sb,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [QUOT_W-1:0]     out_q,
    output logic [REM_W-1:0]      out_r,
    output logic [SB_W-1:0]       out_sb
);

    localparam longint unsigned RECIP = (64'd1 << SHIFT) / longint'(DIVISOR);
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PW      = DIVIDEND_W + RECIP_W;

    localparam logic [PW-1:0]         RECIP_V   = PW'(RECIP);
    localparam logic [DIVIDEND_W-1:0] DIVISOR_V = DIVIDEND_W'(DIVISOR);

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  rdy1, rdy2, rdy3;

    logic [PW-1:0]         prod_reg, prod_next;
    logic [DIVIDEND_W-1:0] x1_reg;
    logic [SB_W-1:0]       sb1_reg;

    logic [QUOT_W-1:0]     q0_reg, q0_next;
    logic [DIVIDEND_W-1:0] back_reg, back_next;
    logic [DIVIDEND_W-1:0] x2_reg;
    logic [SB_W-1:0]       sb2_reg;

    logic [DIVIDEND_W-1:0] diff;
    logic [QUOT_W-1:0]     q_reg, q_next;
    logic [REM_W-1:0]      r_reg, r_next;
    logic [SB_W-1:0]       sb3_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // The truncated reciprocal underestimates by at most one.
    assign prod_next = PW'(in_x) * RECIP_V;
    assign q0_next   = prod_reg[SHIFT +: QUOT_W];
    assign back_next = DIVIDEND_W'(DIVIDEND_W'(q0_next) * DIVISOR_V);

    always_comb begin
        diff = x2_reg - back_reg;
        if (diff >= DIVISOR_V) begin
            q_next = q0_reg + QUOT_W'(1);
            r_next = REM_W'(diff - DIVISOR_V);
        end else begin
            q_next = q0_reg;
            r_next = REM_W'(diff);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            prod_reg <= prod_next;
            x1_reg   <= in_x;
            sb1_reg  <= in_sb;
        end
        if (rdy2 && v1_reg) begin
            q0_reg   <= q0_next;
            back_reg <= back_next;
            x2_reg   <= x1_reg;
            sb2_reg  <= sb1_reg;
        end
        if (rdy3 && v2_reg) begin
            q_reg   <= q_next;
            r_reg   <= r_next;
            sb3_reg <= sb2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_q     = q_reg;
    assign out_r     = r_reg;
    assign out_sb    = sb3_reg;

    a_back_le_x: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> back_reg <= x2_reg)
        else $error("quotient estimate overshoots the dividend");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> DIVIDEND_W'(r_reg) < DIVISOR_V)
        else $error("remainder not below the divisor");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_q) && $stable(out_r))
        else $error("held result changed while stalled");

endmodule

### rtl/lsw_core.sv
// ----------------------------------------------------------------------------
// Lap stopwatch command core
// Applies each command to the total, run flag and lap count, computes the
// sub-period time, and writes or reads the lap RAM in four pipeline stages.
// ----------------------------------------------------------------------------
module lsw_core
    import lsw_pkg::*;
#(
    parameter int LAP_DEPTH = LAP_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [TICKS_W-1:0]  s_timer_ticks,
    input  logic [INDEX_W-1:0]  s_lap_index,
    output logic                out_valid,
    input  logic                out_ready,
    output res_info_t           out_info
);

    localparam int AW     = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LAP_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    localparam logic [SUB_PROD_W-1:0]  SUB_MUL_V   = SUB_PROD_W'(SUB_MUL);
    localparam logic [SUB_RECIP_W-1:0] SUB_RECIP_V = SUB_RECIP_W'(SUB_RECIP);
    localparam int SUB_FULL_W = SUB_PROD_W + SUB_RECIP_W;

    typedef struct packed {
        status_t             status;
        sel_t                sel;
        logic                do_write;
        logic                do_read;
        logic [AW-1:0]       waddr;
        logic [AW-1:0]       raddr;
        logic [VALUE_W-1:0]  total;
        logic                running;
        logic [LAPS_W-1:0]   laps;
    } ctl_t;

    logic [PERIOD_W-1:0] period_reg;
    logic [VALUE_W-1:0]  total_reg, total_next;
    logic                run_reg, run_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic                accept;
    cmd_t                cmd;
    ctl_t                ctl_next;

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic                rdy1, rdy2, rdy3, rdy4;
    ctl_t                ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;

    logic [SUB_PROD_W-1:0] prod_reg, prod_next;
    logic [SUB_FULL_W-1:0] sub_full;
    logic [SUB_W-1:0]      sub_reg;
    logic [VALUE_W-1:0]    sum3_reg, sum4_reg;

    logic                ram_we, ram_re;
    logic [VALUE_W-1:0]  ram_rdata;

    assign rdy4    = !v4_reg || out_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign accept  = s_valid && s_ready;
    assign cmd     = cmd_t'(s_cmd);

    always_comb begin
        total_next        = total_reg;
        run_next          = run_reg;
        count_next        = count_reg;
        ctl_next.status   = ST_OK;
        ctl_next.sel      = SEL_TOTAL;
        ctl_next.do_write = 1'b0;
        ctl_next.do_read  = 1'b0;
        ctl_next.waddr    = AW'(count_reg);
        ctl_next.raddr    = AW'(s_lap_index);
        unique case (cmd)
            CMD_PERIOD: begin
                if (run_reg) begin
                    total_next = total_reg + VALUE_W'(period_reg);
                end
            end
            CMD_RESET: begin
                total_next = '0;
                run_next   = 1'b0;
                count_next = '0;
            end
            CMD_START: begin
                run_next = 1'b1;
            end
            CMD_STOP: begin
                run_next = 1'b0;
            end
            CMD_LAP: begin
                if (count_reg >= CNT_W'(LAP_DEPTH)) begin
                    ctl_next.status = ST_FULL;
                end else begin
                    ctl_next.sel      = SEL_SUM;
                    ctl_next.do_write = 1'b1;
                    count_next        = count_reg + CNT_W'(1);
                end
            end
            CMD_RD_TOTAL: begin
                ctl_next.sel = SEL_TOTAL;
            end
            CMD_RD_SUM: begin
                ctl_next.sel = SEL_SUM;
            end
            CMD_RD_LAP: begin
                // The count never exceeds the depth, so this also bounds the index.
                if (CMP_W'(s_lap_index) < CMP_W'(count_reg)) begin
                    ctl_next.sel     = SEL_LAP;
                    ctl_next.do_read = 1'b1;
                end else begin
                    ctl_next.status = ST_UNWRITTEN;
                end
            end
            default: begin
                ctl_next.sel = SEL_TOTAL;
            end
        endcase
        ctl_next.total   = total_next;
        ctl_next.running = run_next;
        ctl_next.laps    = LAPS_W'(count_next);
    end

    assign prod_next = SUB_PROD_W'(s_timer_ticks) * SUB_MUL_V;
    assign sub_full  = SUB_FULL_W'(prod_reg) * SUB_FULL_W'(SUB_RECIP_V);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
            total_reg  <= '0;
            run_reg    <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            if (accept) begin
                total_reg <= total_next;
                run_reg   <= run_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctl1_reg <= ctl_next;
            prod_reg <= prod_next;
        end
        if (rdy2 && v1_reg) begin
            ctl2_reg <= ctl1_reg;
            sub_reg  <= sub_full[SUB_SHIFT +: SUB_W];
        end
        if (rdy3 && v2_reg) begin
            ctl3_reg <= ctl2_reg;
            sum3_reg <= ctl2_reg.total + VALUE_W'(sub_reg);
        end
        if (rdy4 && v3_reg) begin
            ctl4_reg <= ctl3_reg;
            sum4_reg <= sum3_reg;
        end
    end

    // Laps are written and read as beats leave the third stage, so the
    // accesses stay in command order and a read sees every earlier write.
    assign ram_we = rdy4 && v3_reg && ctl3_reg.do_write;
    assign ram_re = rdy4 && v3_reg && ctl3_reg.do_read;

    lsw_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LAP_DEPTH),
        .AW    (AW)
    ) u_lap_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ctl3_reg.waddr),
        .wdata (sum3_reg),
        .re    (ram_re),
        .raddr (ctl3_reg.raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        out_info.status  = ctl4_reg.status;
        out_info.running = ctl4_reg.running;
        out_info.laps    = ctl4_reg.laps;
        unique case (ctl4_reg.sel)
            SEL_SUM: out_info.value = sum4_reg;
            SEL_LAP: out_info.value = ram_rdata;
            default: out_info.value = ctl4_reg.total;
        endcase
    end

    assign out_valid = v4_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LAP_DEPTH))
        else $error("lap count beyond store depth");

    a_ram_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("lap RAM written and read by the same beat");

    a_reset_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_RESET |=> total_reg == '0 && count_reg == '0 && !run_reg)
        else $error("reset command did not clear the stopwatch");

    a_stopped_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_PERIOD && !run_reg |=> $stable(total_reg))
        else $error("total moved while stopped");

endmodule

### rtl/lap_stopwatch_with_time_format.sv
// ----------------------------------------------------------------------------
// Lap stopwatch with time format
// Millisecond stopwatch with a lap store; every command returns one result
// with the selected time split into hours, minutes, seconds and milliseconds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one command per beat (period event, reset, start,
//   stop, lap, read total, read total plus ticks, read lap). Result channel
//   m_*: exactly one beat per command, in command order.
//   cfg_wr_en/cfg_wr_data write the period in milliseconds; write it only
//   while no command is in flight.
//   Throughput: one command per cycle while m_ready is high. Each command
//   passes from the accepting edge to m_valid through the four-stage command
//   pipe (tick scaling, lap RAM access with registered read) and three
//   three-stage constant dividers for hours, minutes and seconds.
//   Reset clears the total, run flag, lap count and all pipeline valids and
//   loads a period of 1000 ms. Lap RAM contents are not cleared; entries at
//   or beyond the lap count are never returned.
//   When m_ready is low, results stay held and the pipeline keeps accepting
//   commands until every stage is full; s_ready then drops.
// ----------------------------------------------------------------------------
module lap_stopwatch_with_time_format
    import lsw_pkg::*;
#(
    parameter int LAP_DEPTH = LAP_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [TICKS_W-1:0]  s_timer_ticks,
    input  logic [INDEX_W-1:0]  s_lap_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [VALUE_W-1:0]  m_value_ms,
    output logic [HOURS_W-1:0]  m_hours,
    output logic [MIN_W-1:0]    m_minutes,
    output logic [SEC_W-1:0]    m_seconds,
    output logic [MS_W-1:0]     m_millis,
    output logic                m_running,
    output logic [LAPS_W-1:0]   m_laps_stored
);

    localparam int INFO_W = $bits(res_info_t);
    localparam int HREM_W = $clog2(HOUR_MS);
    localparam int MREM_W = $clog2(MINUTE_MS);
    localparam int SB_H_W = INFO_W;
    localparam int SB_M_W = INFO_W + HOURS_W;
    localparam int SB_S_W = INFO_W + HOURS_W + MIN_W;

    logic                core_valid, core_ready;
    res_info_t           core_info;

    logic                h_valid, h_ready;
    logic [HOURS_W-1:0]  h_q;
    logic [HREM_W-1:0]   h_r;
    logic [SB_H_W-1:0]   h_sb;

    logic                mn_valid, mn_ready;
    logic [MIN_W-1:0]    mn_q;
    logic [MREM_W-1:0]   mn_r;
    logic [SB_M_W-1:0]   mn_sb;

    logic [SB_S_W-1:0]   sec_sb;
    res_info_t           res_info;

    lsw_core #(
        .LAP_DEPTH (LAP_DEPTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_timer_ticks (s_timer_ticks),
        .s_lap_index   (s_lap_index),
        .out_valid     (core_valid),
        .out_ready     (core_ready),
        .out_info      (core_info)
    );

    lsw_cdiv #(
        .DIVIDEND_W (VALUE_W),
        .QUOT_W     (HOURS_W),
        .DIVISOR    (HOUR_MS),
        .SHIFT      (HOUR_SHIFT),
        .SB_W       (SB_H_W),
        .REM_W      (HREM_W)
    ) u_div_hours (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (core_valid),
        .in_ready  (core_ready),
        .in_x      (core_info.value),
        .in_sb     (core_info),
        .out_valid (h_valid),
        .out_ready (h_ready),
        .out_q     (h_q),
        .out_r     (h_r),
        .out_sb    (h_sb)
    );

    lsw_cdiv #(
        .DIVIDEND_W (HREM_W),
        .QUOT_W     (MIN_W),
        .DIVISOR    (MINUTE_MS),
        .SHIFT      (MINUTE_SHIFT),
        .SB_W       (SB_M_W),
        .REM_W      (MREM_W)
    ) u_div_minutes (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (h_valid),
        .in_ready  (h_ready),
        .in_x      (h_r),
        .in_sb     ({h_sb, h_q}),
        .out_valid (mn_valid),
        .out_ready (mn_ready),
        .out_q     (mn_q),
        .out_r     (mn_r),
        .out_sb    (mn_sb)
    );

    // The last divider's third stage is the result register.
    lsw_cdiv #(
        .DIVIDEND_W (MREM_W),
        .QUOT_W     (SEC_W),
        .DIVISOR    (SECOND_MS),
        .SHIFT      (SECOND_SHIFT),
        .SB_W       (SB_S_W),
        .REM_W      (MS_W)
    ) u_div_seconds (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mn_valid),
        .in_ready  (mn_ready),
        .in_x      (mn_r),
        .in_sb     ({mn_sb, mn_q}),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_q     (m_seconds),
        .out_r     (m_millis),
        .out_sb    (sec_sb)
    );

    assign res_info      = res_info_t'(sec_sb[SB_S_W-1 -: INFO_W]);
    assign m_hours       = sec_sb[MIN_W +: HOURS_W];
    assign m_minutes     = sec_sb[MIN_W-1:0];
    assign m_status      = res_info.status;
    assign m_value_ms    = res_info.value;
    assign m_running     = res_info.running;
    assign m_laps_stored = res_info.laps;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap stopwatch testbench
// Sends command beats in random bursts while the result port stalls on its
// own pattern. A behavioral stopwatch predicts every readout, and each result
// field is compared with it. The run covers several period settings, a full
// lap store, and a full-rate run at the largest period past one hour.
// ----------------------------------------------------------------------------
module tb;
    import lsw_pkg::*;

    localparam int LAPS_MAX    = LAP_DEPTH_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE      = 20;
    localparam int MAX_PRINTS  = 40;
    localparam int LONG_EVENTS = 60;

    typedef struct packed {
        cmd_t               cmd;
        logic [TICKS_W-1:0] ticks;
        logic [INDEX_W-1:0] index;
    } command_t;

    typedef struct packed {
        status_t             status;
        logic [VALUE_W-1:0]  value;
        logic [HOURS_W-1:0]  hours;
        logic [MIN_W-1:0]    minutes;
        logic [SEC_W-1:0]    seconds;
        logic [MS_W-1:0]     millis;
        logic                running;
        logic [LAPS_W-1:0]   laps;
    } readout_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [PERIOD_W-1:0] cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd = '0;
    logic [TICKS_W-1:0]  s_timer_ticks = '0;
    logic [INDEX_W-1:0]  s_lap_index = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [1:0]          m_status;
    logic [VALUE_W-1:0]  m_value_ms;
    logic [HOURS_W-1:0]  m_hours;
    logic [MIN_W-1:0]    m_minutes;
    logic [SEC_W-1:0]    m_seconds;
    logic [MS_W-1:0]     m_millis;
    logic                m_running;
    logic [LAPS_W-1:0]   m_laps_stored;

    // Behavioral copy of the stopwatch state and its period register.
    logic [PERIOD_W-1:0] sw_period = PERIOD_RESET;
    logic [VALUE_W-1:0]  sw_total = '0;
    logic                sw_running = 1'b0;
    logic [LAPS_W-1:0]   sw_laps = '0;
    logic [VALUE_W-1:0]  lap_mem [LAPS_MAX];

    command_t command_q[$];
    readout_t pending_readouts[$];
    command_t next_cmd;
    command_t accepted_cmd;
    readout_t want;

    logic    in_beat = 1'b0;
    logic    fast_run = 1'b0;
    int      burst_left = 0;
    int      gap_left = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int      ready_bit = 0;
    int      stim_laps = 0;
    int      idle_cycles;

    int n_queued = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_full = 0;
    int n_unwritten = 0;
    int n_settings = 1;

    lap_stopwatch_with_time_format dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_timer_ticks (s_timer_ticks),
        .s_lap_index   (s_lap_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_value_ms    (m_value_ms),
        .m_hours       (m_hours),
        .m_minutes     (m_minutes),
        .m_seconds     (m_seconds),
        .m_millis      (m_millis),
        .m_running     (m_running),
        .m_laps_stored (m_laps_stored)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [VALUE_W-1:0] tick_ms(input logic [TICKS_W-1:0] t);
        return ({16'd0, t} * SUB_MUL) / SUB_DIV;
    endfunction

    function automatic readout_t format_readout(input status_t st,
                                                input logic [VALUE_W-1:0] v);
        readout_t r;
        r.status  = st;
        r.value   = v;
        r.hours   = HOURS_W'(v / HOUR_MS);
        r.minutes = MIN_W'((v % HOUR_MS) / MINUTE_MS);
        r.seconds = SEC_W'((v % MINUTE_MS) / SECOND_MS);
        r.millis  = MS_W'(v % SECOND_MS);
        r.running = sw_running;
        r.laps    = sw_laps;
        return r;
    endfunction

    task automatic advance_stopwatch(input command_t c);
        status_t            st;
        logic [VALUE_W-1:0] v;
        st = ST_OK;
        case (c.cmd)
            CMD_PERIOD: begin
                if (sw_running) begin
                    sw_total = sw_total + VALUE_W'(sw_period);
                end
                v = sw_total;
            end
            CMD_RESET: begin
                sw_total = '0;
                sw_laps = '0;
                sw_running = 1'b0;
                v = sw_total;
            end
            CMD_START: begin
                sw_running = 1'b1;
                v = sw_total;
            end
            CMD_STOP: begin
                sw_running = 1'b0;
                v = sw_total;
            end
            CMD_LAP: begin
                if (sw_laps >= LAPS_W'(LAPS_MAX)) begin
                    st = ST_FULL;
                    v = sw_total;
                    n_full++;
                end else begin
                    v = sw_total + tick_ms(c.ticks);
                    lap_mem[sw_laps[INDEX_W-1:0]] = v;
                    sw_laps = sw_laps + LAPS_W'(1);
                end
            end
            CMD_RD_TOTAL: v = sw_total;
            CMD_RD_SUM:   v = sw_total + tick_ms(c.ticks);
            default: begin
                if (LAPS_W'(c.index) < sw_laps) begin
                    v = lap_mem[c.index];
                end else begin
                    st = ST_UNWRITTEN;
                    v = sw_total;
                    n_unwritten++;
                end
            end
        endcase
        pending_readouts.push_back(format_readout(st, v));
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        n_errors++;
        if (n_errors <= MAX_PRINTS) begin
            $display("[%0t] result %0d: %s got %0d, expected %0d",
                     $time, n_checked, what, got, exp_val);
        end
    endtask

    // Driver: one command beat per free slot, grouped in bursts with gaps.
    always @(negedge aclk) begin
        if (s_valid && !in_beat) begin
            // Beat not taken yet; payload holds.
        end else if (gap_left != 0 && !fast_run) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (command_q.size() != 0) begin
            next_cmd = command_q.pop_front();
            s_cmd <= next_cmd.cmd;
            s_timer_ticks <= next_cmd.ticks;
            s_lap_index <= next_cmd.index;
            s_valid <= 1'b1;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
                burst_left--;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: ready follows a 16-bit pattern that is redrawn each time it runs out.
    always @(negedge aclk) begin
        if (fast_run || !aresetn) begin
            m_ready <= 1'b1;
        end else begin
            if (ready_bit == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'($urandom);
                    2:       ready_pattern = 16'h00FF;
                    default: ready_pattern = 16'hB6DB;
                endcase
                ready_bit = 15;
            end else begin
                ready_bit--;
            end
            m_ready <= ready_pattern[ready_bit];
        end
    end

    always @(posedge aclk) begin
        in_beat <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            accepted_cmd.cmd = cmd_t'(s_cmd);
            accepted_cmd.ticks = s_timer_ticks;
            accepted_cmd.index = s_lap_index;
            advance_stopwatch(accepted_cmd);
            n_accepted++;
        end
        if (aresetn && m_valid && m_ready) begin
            n_checked++;
            if (pending_readouts.size() == 0) begin
                report_mismatch("value_ms with no result pending", m_value_ms, 0);
            end else begin
                want = pending_readouts.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", 32'(m_status), 32'(want.status));
                if (m_value_ms !== want.value)
                    report_mismatch("value_ms", m_value_ms, want.value);
                if (m_hours !== want.hours)
                    report_mismatch("hours", 32'(m_hours), 32'(want.hours));
                if (m_minutes !== want.minutes)
                    report_mismatch("minutes", 32'(m_minutes), 32'(want.minutes));
                if (m_seconds !== want.seconds)
                    report_mismatch("seconds", 32'(m_seconds), 32'(want.seconds));
                if (m_millis !== want.millis)
                    report_mismatch("millis", 32'(m_millis), 32'(want.millis));
                if (m_running !== want.running)
                    report_mismatch("running", 32'(m_running), 32'(want.running));
                if (m_laps_stored !== want.laps)
                    report_mismatch("laps_stored", 32'(m_laps_stored), 32'(want.laps));
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timed out: no beat for %0d cycles, %0d results pending",
                 IDLE_LIMIT, pending_readouts.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [TICKS_W-1:0] random_ticks();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return TICKS_W'($urandom);
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] random_index();
        return INDEX_W'($urandom);
    endfunction

    task automatic queue_command(input cmd_t c, input logic [TICKS_W-1:0] t,
                                 input logic [INDEX_W-1:0] i);
        command_t x;
        x.cmd = c;
        x.ticks = t;
        x.index = i;
        command_q.push_back(x);
        n_queued++;
    endtask

    function automatic logic [INDEX_W-1:0] pick_lap_index();
        if (stim_laps != 0 && $urandom_range(0, 3) != 0) begin
            return INDEX_W'($urandom_range(0, stim_laps - 1));
        end
        return INDEX_W'($urandom_range(0, LAPS_MAX - 1));
    endfunction

    task automatic mixed_commands(input int n, input int reset_pct);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < reset_pct) begin
                queue_command(CMD_RESET, random_ticks(), random_index());
                stim_laps = 0;
            end else if (r < reset_pct + 4) begin
                queue_command(cmd_t'($urandom_range(0, 7)), TICKS_W'($urandom),
                              random_index());
            end else if (r < 40) begin
                queue_command(CMD_PERIOD, TICKS_W'($urandom), random_index());
            end else if (r < 55) begin
                queue_command(CMD_LAP, random_ticks(), random_index());
                if (stim_laps < LAPS_MAX) stim_laps++;
            end else if (r < 70) begin
                queue_command(CMD_RD_LAP, TICKS_W'($urandom), pick_lap_index());
            end else if (r < 78) begin
                queue_command(CMD_RD_SUM, random_ticks(), random_index());
            end else if (r < 84) begin
                queue_command(CMD_RD_TOTAL, TICKS_W'($urandom), random_index());
            end else if (r < 92) begin
                queue_command(CMD_START, TICKS_W'($urandom), random_index());
            end else begin
                queue_command(CMD_STOP, TICKS_W'($urandom), random_index());
            end
        end
    endtask

    // Runs the lap store past full, with periods and reads mixed in.
    task automatic fill_lap_store();
        queue_command(CMD_RESET, TICKS_W'($urandom), random_index());
        queue_command(CMD_START, TICKS_W'($urandom), random_index());
        stim_laps = 0;
        repeat (LAPS_MAX + 6) begin
            queue_command(CMD_LAP, random_ticks(), random_index());
            if (stim_laps < LAPS_MAX) stim_laps++;
            if ($urandom_range(0, 1) == 0)
                queue_command(CMD_PERIOD, TICKS_W'($urandom), random_index());
            if ($urandom_range(0, 2) == 0)
                queue_command(CMD_RD_LAP, TICKS_W'($urandom), pick_lap_index());
        end
        queue_command(CMD_STOP, TICKS_W'($urandom), random_index());
        repeat (8) queue_command(CMD_RD_LAP, TICKS_W'($urandom), random_index());
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || pending_readouts.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_period(input logic [PERIOD_W-1:0] p);
        wait_idle();
        cfg_wr_data <= p;
        cfg_wr_en <= 1'b1;
        sw_period = p;
        n_settings++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed pass at the reset period of one second.
        queue_command(CMD_RD_TOTAL, 16'h0000, 6'd0);
        queue_command(CMD_PERIOD,   16'h0000, 6'd0);
        queue_command(CMD_RD_LAP,   16'h0000, 6'd0);
        queue_command(CMD_START,    16'h0000, 6'd0);
        queue_command(CMD_PERIOD,   16'hFFFF, 6'd63);
        queue_command(CMD_PERIOD,   16'h0000, 6'd0);
        queue_command(CMD_RD_SUM,   16'h0000, 6'd0);
        queue_command(CMD_RD_SUM,   16'hFFFF, 6'd0);
        queue_command(CMD_LAP,      16'hFFFF, 6'd0);
        queue_command(CMD_LAP,      16'h0000, 6'd0);
        queue_command(CMD_LAP,      16'hAAAA, 6'd0);
        queue_command(CMD_RD_LAP,   16'h0000, 6'd0);
        queue_command(CMD_RD_LAP,   16'h0000, 6'd2);
        queue_command(CMD_RD_LAP,   16'h0000, 6'd3);
        queue_command(CMD_RD_LAP,   16'h0000, 6'd63);
        queue_command(CMD_STOP,     16'h0000, 6'd0);
        queue_command(CMD_PERIOD,   16'h0000, 6'd0);
        queue_command(CMD_RD_TOTAL, 16'h0000, 6'd0);
        queue_command(CMD_LAP,      16'h5555, 6'd0);
        queue_command(CMD_RD_LAP,   16'h0000, 6'h15);
        queue_command(CMD_RD_LAP,   16'h0000, 6'h2A);
        queue_command(CMD_RESET,    16'h0000, 6'd0);
        queue_command(CMD_RD_LAP,   16'h0000, 6'd0);
        queue_command(CMD_RD_TOTAL, 16'h0000, 6'd0);

        set_period(16'hFFFF);
        mixed_commands(90, 3);

        set_period(16'd1);
        fill_lap_store();

        set_period(16'd0);
        mixed_commands(80, 3);

        set_period(PERIOD_W'($urandom_range(2, 65534)));
        mixed_commands(90, 3);

        // Largest period at full rate, long enough to carry the total past an hour.
        set_period(16'hFFFF);
        fast_run <= 1'b1;
        stim_laps = 0;
        queue_command(CMD_RESET, 16'h0000, 6'd0);
        queue_command(CMD_START, 16'h0000, 6'd0);
        repeat (LONG_EVENTS) queue_command(CMD_PERIOD, TICKS_W'($urandom), random_index());
        queue_command(CMD_RD_TOTAL, 16'h0000, 6'd0);
        queue_command(CMD_RD_SUM,   16'hFFFF, 6'd0);
        queue_command(CMD_LAP,      16'hFFFF, 6'd0);
        queue_command(CMD_LAP,      16'h0000, 6'd0);
        queue_command(CMD_RD_LAP,   16'h0000, 6'd0);
        queue_command(CMD_RD_LAP,   16'h0000, 6'd1);
        queue_command(CMD_PERIOD,   16'h0000, 6'd0);
        queue_command(CMD_RD_TOTAL, 16'h0000, 6'd0);
        stim_laps = 2;
        while (n_accepted != n_queued) @(negedge aclk);
        fast_run <= 1'b0;
        mixed_commands(60, 0);

        wait_idle();
        $display("Checked %0d results from %0d commands over %0d period settings.",
                 n_checked, n_accepted, n_settings);
        $display("Full lap store hit %0d times, unwritten lap index %0d times, %0d mismatches.",
                 n_full, n_unwritten, n_errors);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
